/* rtl/mgdm_pkg.sv */
// shared types, register codes and defaults for the mho ground distance unit
`timescale 1ns / 1ps

package mgdm_pkg;

    // default datapath sizing
    localparam int PHASOR_WIDTH_DEF    = 16;
    localparam int RATIO_FRAC_BITS_DEF = 12;

    // configuration register indexes
    localparam logic [2:0] CFG_ZONE1_REACH = 3'd0;
    localparam logic [2:0] CFG_ZONE2_REACH = 3'd1;
    localparam logic [2:0] CFG_ANGLE_COS   = 3'd2;
    localparam logic [2:0] CFG_ANGLE_SIN   = 3'd3;
    localparam logic [2:0] CFG_K0_REAL     = 3'd4;
    localparam logic [2:0] CFG_K0_IMAG     = 3'd5;
    localparam logic [2:0] CFG_LINE_MAG    = 3'd6;

    // register reset values
    localparam logic [15:0] RST_ZONE1_REACH = 16'd3277;
    localparam logic [15:0] RST_ZONE2_REACH = 16'd4915;
    localparam logic [15:0] RST_ANGLE_COS   = 16'd16384;
    localparam logic [15:0] RST_ANGLE_SIN   = 16'd0;
    localparam logic [15:0] RST_K0_REAL     = 16'd0;
    localparam logic [15:0] RST_K0_IMAG     = 16'd0;
    localparam logic [15:0] RST_LINE_MAG    = 16'd256;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_XR0, OP_XR1, OP_XR2,
        OP_XI0, OP_XI1, OP_XI2,
        OP_YR0, OP_YR1,
        OP_YI0, OP_YI1,
        OP_D0,  OP_D1,
        OP_N0,  OP_N1,
        OP_DEN,
        OP_OVF,
        OP_DIV,
        OP_FIN
    } t_op;

    // sequencer step positions
    localparam logic [5:0] STEP_DEN      = 6'd14;
    localparam logic [5:0] STEP_OVF      = 6'd15;
    localparam logic [5:0] STEP_DIV_LAST = 6'd39;
    localparam logic [5:0] STEP_FIN      = 6'd40;

    typedef struct packed {
        t_op  op;
        logic capture;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
    } t_stat;

endpackage

/* rtl/mgdm_ctrl.sv */
// sequencer for the per-phase multiply, divide and compare steps
`timescale 1ns / 1ps

module mgdm_ctrl
    import mgdm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_step, n_step;
    logic [1:0] r_phase, n_phase;
    logic       r_valid, n_valid;
    t_op        w_op;
    logic       w_publish;

    // step to operation map
    always_comb begin
        case (r_step)
            6'd0:    w_op = OP_XR0;
            6'd1:    w_op = OP_XR1;
            6'd2:    w_op = OP_XR2;
            6'd3:    w_op = OP_XI0;
            6'd4:    w_op = OP_XI1;
            6'd5:    w_op = OP_XI2;
            6'd6:    w_op = OP_YR0;
            6'd7:    w_op = OP_YR1;
            6'd8:    w_op = OP_YI0;
            6'd9:    w_op = OP_YI1;
            6'd10:   w_op = OP_D0;
            6'd11:   w_op = OP_D1;
            6'd12:   w_op = OP_N0;
            6'd13:   w_op = OP_N1;
            STEP_DEN: w_op = OP_DEN;
            STEP_OVF: w_op = OP_OVF;
            STEP_FIN: w_op = OP_FIN;
            default: w_op = OP_DIV;
        endcase
    end

    assign w_publish = (r_state == S_DONE) && (!r_valid || !i_stall);

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_phase = r_phase;
        n_valid = r_valid;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RUN;
                    n_step  = 6'd0;
                    n_phase = 2'd0;
                end
            end
            S_RUN: begin
                if (r_step == STEP_FIN) begin
                    n_step = 6'd0;
                    if (r_phase == 2'd2) begin
                        n_state = S_DONE;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end else if (r_step == STEP_OVF && i_stat.den_zero) begin
                    // no division for a zero denominator
                    n_step = STEP_FIN;
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            S_DONE: begin
                if (w_publish) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 6'd0;
            r_phase <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    // commands
    always_comb begin
        o_cmd.op      = (r_state == S_RUN) ? w_op : OP_NONE;
        o_cmd.capture = (r_state == S_IDLE) && i_valid;
        o_cmd.publish = w_publish;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

/* rtl/mgdm_dpath.sv */
// datapath: shared multiply-accumulate, restoring divider, zone compare
`timescale 1ns / 1ps

module mgdm_dpath
    import mgdm_pkg::*;
#(
    parameter int PHASOR_WIDTH    = PHASOR_WIDTH_DEF,
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    output t_stat                          o_stat,
    input  logic                           i_cfg_valid,
    input  logic [2:0]                     i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic signed [PHASOR_WIDTH-1:0] i_va_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_va_im,
    input  logic signed [PHASOR_WIDTH-1:0] i_vb_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_vb_im,
    input  logic signed [PHASOR_WIDTH-1:0] i_vc_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_vc_im,
    input  logic signed [PHASOR_WIDTH-1:0] i_ia_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_ia_im,
    input  logic signed [PHASOR_WIDTH-1:0] i_ib_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_ib_im,
    input  logic signed [PHASOR_WIDTH-1:0] i_ic_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_ic_im,
    output logic signed [23:0]             o_ratio_a,
    output logic signed [23:0]             o_ratio_b,
    output logic signed [23:0]             o_ratio_c,
    output logic                           o_zone1_pickup,
    output logic                           o_zone2_pickup,
    output logic [2:0]                     o_invalid_loops
);

    localparam int P    = PHASOR_WIDTH;
    localparam int WS   = P + 2;
    localparam int WX   = P + 19;
    localparam int WY   = P + 21;
    localparam int WDM  = 2 * P + 20;
    localparam int WA   = WDM + 1;
    localparam int WB   = (P > 17) ? P : 17;
    localparam int WM   = WA + WB;
    localparam int WACC = WM + 1;
    localparam int WN   = 2 * P;
    localparam int WDEN = 2 * P + 36;
    localparam int WR   = 2 * P + 62;
    localparam int MSH  = (RATIO_FRAC_BITS >= 12) ? 0 : 12 - RATIO_FRAC_BITS;
    localparam int RSH  = (RATIO_FRAC_BITS >= 12) ? RATIO_FRAC_BITS - 12 : 0;
    localparam int CW   = 26 + MSH + RSH;
    localparam int NSH  = 21 + RATIO_FRAC_BITS;

    localparam logic signed [23:0] RATIO_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] RATIO_MIN = 24'sh800000;

    typedef enum logic [1:0] {
        M_LOAD,
        M_ADD,
        M_SUB
    } t_mode;

    // configuration registers
    logic [15:0]        r_reach1, r_reach2, r_mag;
    logic signed [15:0] r_cos, r_sin, r_k0r, r_k0i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach1 <= RST_ZONE1_REACH;
            r_reach2 <= RST_ZONE2_REACH;
            r_cos    <= RST_ANGLE_COS;
            r_sin    <= RST_ANGLE_SIN;
            r_k0r    <= RST_K0_REAL;
            r_k0i    <= RST_K0_IMAG;
            r_mag    <= RST_LINE_MAG;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ZONE1_REACH: r_reach1 <= i_cfg_data;
                CFG_ZONE2_REACH: r_reach2 <= i_cfg_data;
                CFG_ANGLE_COS:   r_cos    <= i_cfg_data;
                CFG_ANGLE_SIN:   r_sin    <= i_cfg_data;
                CFG_K0_REAL:     r_k0r    <= i_cfg_data;
                CFG_K0_IMAG:     r_k0i    <= i_cfg_data;
                CFG_LINE_MAG:    r_mag    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // phase operands, position 0 is the loop under work
    logic signed [P-1:0]  r_vre [3];
    logic signed [P-1:0]  r_vim [3];
    logic signed [P-1:0]  r_cre [3];
    logic signed [P-1:0]  r_cim [3];
    logic signed [WS-1:0] r_sr, r_si;

    // per-loop working registers
    logic signed [WACC-1:0] r_acc, n_acc;
    logic signed [WX-1:0]   r_xr, r_xi;
    logic signed [WY-1:0]   r_yr, r_yi;
    logic [WDM-1:0]         r_dmag;
    logic                   r_dneg;
    logic [WN-1:0]          r_nsq;
    logic [WDEN-1:0]        r_den;
    logic                   r_den_zero;
    logic [WR-1:0]          r_rem, r_dv;
    logic                   r_ovf;
    logic [23:0]            r_q;

    // staged results and sticky flags
    logic signed [23:0] r_ra, r_rb, r_rc;
    logic [2:0]         r_inv;
    logic               r_z1, r_z2;

    // multiplier operand selection
    logic signed [WA-1:0] w_a;
    logic signed [WB-1:0] w_b;
    logic signed [WM-1:0] w_prod;
    t_mode                w_mode;

    always_comb begin
        w_a    = '0;
        w_b    = '0;
        w_mode = M_LOAD;
        case (i_cmd.op)
            OP_XR0: begin w_a = WA'(r_cre[0]); w_b = WB'(12288); end
            OP_XR1: begin w_a = WA'(r_sr); w_b = WB'(r_k0r); w_mode = M_ADD; end
            OP_XR2: begin w_a = WA'(r_si); w_b = WB'(r_k0i); w_mode = M_SUB; end
            OP_XI0: begin w_a = WA'(r_cim[0]); w_b = WB'(12288); end
            OP_XI1: begin w_a = WA'(r_si); w_b = WB'(r_k0r); w_mode = M_ADD; end
            OP_XI2: begin w_a = WA'(r_sr); w_b = WB'(r_k0i); w_mode = M_ADD; end
            OP_YR0: begin w_a = WA'(r_xr); w_b = WB'(r_cos); end
            OP_YR1: begin w_a = WA'(r_xi); w_b = WB'(r_sin); w_mode = M_SUB; end
            OP_YI0: begin w_a = WA'(r_xi); w_b = WB'(r_cos); end
            OP_YI1: begin w_a = WA'(r_xr); w_b = WB'(r_sin); w_mode = M_ADD; end
            OP_D0:  begin w_a = WA'(r_yr); w_b = WB'(r_vre[0]); end
            OP_D1:  begin w_a = WA'(r_yi); w_b = WB'(r_vim[0]); w_mode = M_ADD; end
            OP_N0:  begin w_a = WA'(r_vre[0]); w_b = WB'(r_vre[0]); end
            OP_N1:  begin w_a = WA'(r_vim[0]); w_b = WB'(r_vim[0]); w_mode = M_ADD; end
            OP_DEN: begin w_a = WA'({1'b0, r_dmag}); w_b = WB'({1'b0, r_mag}); end
            default: ;
        endcase
    end

    assign w_prod = w_a * w_b;

    // accumulate
    always_comb begin
        case (w_mode)
            M_ADD:   n_acc = r_acc + WACC'(w_prod);
            M_SUB:   n_acc = r_acc - WACC'(w_prod);
            default: n_acc = WACC'(w_prod);
        endcase
    end

    // rounded shift by the angle scale
    logic signed [WACC-1:0] w_rnd, w_shr;
    assign w_rnd = n_acc + (WACC'(1) <<< 13);
    assign w_shr = w_rnd >>> 14;

    // numerator plus denominator for round to nearest
    logic [WN+1:0]   w_nsq3;
    logic [WDEN-1:0] w_den;
    assign w_nsq3 = {r_nsq, 1'b0} + (WN+2)'(r_nsq);
    assign w_den  = w_prod[WDEN-1:0];

    // restoring divide step
    logic [WR:0] w_trial;
    logic        w_qbit;
    assign w_trial = {1'b0, r_rem} - {1'b0, r_dv};
    assign w_qbit  = !w_trial[WR];

    // saturated ratio
    logic signed [23:0] w_m;
    always_comb begin
        if (r_den_zero) begin
            w_m = RATIO_MAX;
        end else if (!r_dneg) begin
            w_m = (r_ovf || r_q[23]) ? RATIO_MAX : $signed(r_q);
        end else if (r_ovf || (r_q[23] && (r_q[22:0] != '0))) begin
            w_m = RATIO_MIN;
        end else begin
            w_m = $signed((~r_q) + 24'd1);
        end
    end

    // reach comparison on aligned scales
    logic signed [CW-1:0] w_ms, w_r1, w_r2;
    assign w_ms = CW'(w_m) <<< MSH;
    assign w_r1 = $signed(CW'(r_reach1)) <<< RSH;
    assign w_r2 = $signed(CW'(r_reach2)) <<< RSH;

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_vre[0] <= i_va_re; r_vim[0] <= i_va_im;
            r_vre[1] <= i_vb_re; r_vim[1] <= i_vb_im;
            r_vre[2] <= i_vc_re; r_vim[2] <= i_vc_im;
            r_cre[0] <= i_ia_re; r_cim[0] <= i_ia_im;
            r_cre[1] <= i_ib_re; r_cim[1] <= i_ib_im;
            r_cre[2] <= i_ic_re; r_cim[2] <= i_ic_im;
            r_sr <= WS'(i_ia_re) + WS'(i_ib_re) + WS'(i_ic_re);
            r_si <= WS'(i_ia_im) + WS'(i_ib_im) + WS'(i_ic_im);
        end
        if (i_cmd.op != OP_NONE) begin
            r_acc <= n_acc;
        end
        case (i_cmd.op)
            OP_XR2: r_xr <= n_acc[WX-1:0];
            OP_XI2: r_xi <= n_acc[WX-1:0];
            OP_YR1: r_yr <= w_shr[WY-1:0];
            OP_YI1: r_yi <= w_shr[WY-1:0];
            OP_D1: begin
                r_dneg <= n_acc[WACC-1];
                r_dmag <= n_acc[WACC-1] ? WDM'(-n_acc) : WDM'(n_acc);
            end
            OP_N1: r_nsq <= n_acc[WN-1:0];
            OP_DEN: begin
                r_den      <= w_den;
                r_den_zero <= (w_den == '0);
                r_rem      <= (WR'(w_nsq3) << NSH) + WR'(w_den);
            end
            OP_OVF: begin
                r_ovf <= (r_rem >= (WR'(r_den) << 25));
                r_dv  <= WR'(r_den) << 24;
                r_q   <= '0;
            end
            OP_DIV: begin
                if (w_qbit) begin
                    r_rem <= w_trial[WR-1:0];
                end
                r_q  <= {r_q[22:0], w_qbit};
                r_dv <= r_dv >> 1;
            end
            OP_FIN: begin
                // rotate the next phase into place
                r_vre[0] <= r_vre[1]; r_vre[1] <= r_vre[2]; r_vre[2] <= r_vre[0];
                r_vim[0] <= r_vim[1]; r_vim[1] <= r_vim[2]; r_vim[2] <= r_vim[0];
                r_cre[0] <= r_cre[1]; r_cre[1] <= r_cre[2]; r_cre[2] <= r_cre[0];
                r_cim[0] <= r_cim[1]; r_cim[1] <= r_cim[2]; r_cim[2] <= r_cim[0];
                r_ra  <= r_rb;
                r_rb  <= r_rc;
                r_rc  <= w_m;
                r_inv <= {r_den_zero, r_inv[2:1]};
            end
            default: ;
        endcase
    end

    // sticky zone flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1 <= 1'b0;
            r_z2 <= 1'b0;
        end else if (i_cmd.op == OP_FIN && !r_den_zero) begin
            if (w_ms > 0 && w_ms < w_r1) begin
                r_z1 <= 1'b1;
            end else if (w_ms > w_r1 && w_ms < w_r2) begin
                r_z2 <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            o_ratio_a       <= r_ra;
            o_ratio_b       <= r_rb;
            o_ratio_c       <= r_rc;
            o_invalid_loops <= r_inv;
            o_zone1_pickup  <= r_z1;
            o_zone2_pickup  <= r_z2;
        end
    end

    assign o_stat.den_zero = r_den_zero;

endmodule

/* rtl/mho_ground_distance_measure_unit.sv */
// mho ground distance measuring unit, top level
// an accepted transaction runs the three phase loops in turn, then loads the output register
//   (41 steps per phase loop: 15 multiply-accumulate steps, overflow check, 24 divide
//   steps, finish; 17 steps per loop with a zero denominator)
// o_stall holds while a transaction is under way, so a new one is accepted only when idle;
//   the pace is set by the shared multiplier and the one-bit-per-cycle restoring divider
// reset: synchronous active low, restores register defaults and clears the sticky pickup flags
`timescale 1ns / 1ps

module mho_ground_distance_measure_unit
    import mgdm_pkg::*;
#(
    parameter int PHASOR_WIDTH    = PHASOR_WIDTH_DEF,
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [PHASOR_WIDTH-1:0] i_va_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_va_im,
    input  logic signed [PHASOR_WIDTH-1:0] i_vb_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_vb_im,
    input  logic signed [PHASOR_WIDTH-1:0] i_vc_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_vc_im,
    input  logic signed [PHASOR_WIDTH-1:0] i_ia_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_ia_im,
    input  logic signed [PHASOR_WIDTH-1:0] i_ib_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_ib_im,
    input  logic signed [PHASOR_WIDTH-1:0] i_ic_re,
    input  logic signed [PHASOR_WIDTH-1:0] i_ic_im,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [23:0]             o_ratio_a,
    output logic signed [23:0]             o_ratio_b,
    output logic signed [23:0]             o_ratio_c,
    output logic                           o_zone1_pickup,
    output logic                           o_zone2_pickup,
    output logic [2:0]                     o_invalid_loops,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [2:0]                     i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // registers accept a write every cycle
    assign o_cfg_ready = 1'b1;

    mgdm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    mgdm_dpath #(
        .PHASOR_WIDTH    (PHASOR_WIDTH),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_va_re         (i_va_re),
        .i_va_im         (i_va_im),
        .i_vb_re         (i_vb_re),
        .i_vb_im         (i_vb_im),
        .i_vc_re         (i_vc_re),
        .i_vc_im         (i_vc_im),
        .i_ia_re         (i_ia_re),
        .i_ia_im         (i_ia_im),
        .i_ib_re         (i_ib_re),
        .i_ib_im         (i_ib_im),
        .i_ic_re         (i_ic_re),
        .i_ic_im         (i_ic_im),
        .o_ratio_a       (o_ratio_a),
        .o_ratio_b       (o_ratio_b),
        .o_ratio_c       (o_ratio_c),
        .o_zone1_pickup  (o_zone1_pickup),
        .o_zone2_pickup  (o_zone2_pickup),
        .o_invalid_loops (o_invalid_loops)
    );

endmodule
